// ===== src/smks_pkg.sv =====
// Shared constants and state encoding for the stable masked key sorter.
// No dependencies; used by the top level, the checker and the testbench.
package smks_pkg;

	localparam int MAX_ACTIONS = 32;                      // list capacity, 2..64
	localparam int ADDR_W      = $clog2(MAX_ACTIONS);     // entry address
	localparam int CNT_W       = $clog2(MAX_ACTIONS + 1); // 0..MAX_ACTIONS
	localparam int WORD_W      = 32;
	localparam int ENTRY_W     = 2 * WORD_W;              // {extra, action}

	typedef enum logic [2:0] {
		ST_LOAD,      // collect pairs from the input stream
		ST_SORT_RD,   // fetch next element to insert
		ST_SORT_KEY,  // latch element, fetch left neighbor
		ST_SORT_CMP,  // compare with neighbor, shift right or place
		ST_SORT_PUT,  // place element at entry zero
		ST_OUT_RD,    // fetch next sorted entry
		ST_OUT_LD     // move fetched entry into output register
	} state_t;

endpackage

// ===== src/stable_masked_key_sorter.sv =====
// Top level of the stable masked key sorter: list capture, in-place insertion
// sort in one entry RAM, and sorted readout. Depends on smks_pkg, smks_ram.
//
//  channel   dir  handshake           payload
//  s_*       in   s_tvalid/s_tready   tdata = action_word, extra_word; tlast = last_item
//  m_*       out  m_tvalid/m_tready   tdata = sorted_action, sorted_extra;
//                                     tlast = end_of_list; tuser = items_dropped
//  cfg_*     in   cfg_wen             cfg_wdata = time_key_mask
//
// Loading accepts one request per cycle in ST_LOAD. On the request marked last, the
// stored list of n pairs is insertion sorted in the RAM: each element is held aside
// while its left neighbours are compared and shifted right, one read at a time on the
// single RAM read port. Readout then moves each fetched result into the output
// register, which lets the next list start loading while the final result waits.
// Reset clears the count, overflow flag, output valid and sets the mask to all ones;
// RAM contents are not cleared. m_tready low only stalls readout.
module stable_masked_key_sorter (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [smks_pkg::ENTRY_W-1:0]  s_tdata,   // [31:0] action_word, [63:32] extra_word
	input  logic                          s_tlast,   // last_item
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [smks_pkg::ENTRY_W-1:0]  m_tdata,   // [31:0] sorted_action, [63:32] sorted_extra
	output logic                          m_tlast,   // end_of_list
	output logic                          m_tuser,   // items_dropped
	input  logic                          cfg_wen,
	input  logic [smks_pkg::WORD_W-1:0]   cfg_wdata  // time_key_mask
);

	localparam int AW = smks_pkg::ADDR_W;
	localparam int CW = smks_pkg::CNT_W;
	localparam int WW = smks_pkg::WORD_W;
	localparam int EW = smks_pkg::ENTRY_W;

	smks_pkg::state_t state_q, state_nxt;

	logic [WW-1:0] mask_q;
	logic [CW-1:0] count_q;     // stored pairs of the current list
	logic          ovf_q;       // a request was dropped from this list
	logic [CW-1:0] ins_q;       // element being inserted
	logic [AW-1:0] pos_q;       // hole position during insertion
	logic [AW-1:0] rd_idx_q;    // readout index
	logic [EW-1:0] cur_q;       // element held out while entries shift

	logic          out_valid_q;
	logic [EW-1:0] out_data_q;
	logic          out_last_q;
	logic          out_drop_q;

	logic          ram_we, ram_re;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [EW-1:0] ram_wdata, ram_rdata;

	logic in_acc, has_room, ins_more, move_up, out_free, last_entry;

	assign in_acc     = s_tvalid && s_tready;
	assign has_room   = count_q < CW'(smks_pkg::MAX_ACTIONS);
	assign ins_more   = ins_q < count_q;
	assign out_free   = !out_valid_q || m_tready;
	assign last_entry = (CW'(rd_idx_q) + CW'(1)) == count_q;

	// signed compare of masked keys; strict so equal keys stay in order
	assign move_up = $signed(ram_rdata[WW-1:0] & mask_q) > $signed(cur_q[WW-1:0] & mask_q);

	smks_ram #(
		.DEPTH(smks_pkg::MAX_ACTIONS),
		.WIDTH(EW)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			smks_pkg::ST_LOAD: begin
				if (in_acc && s_tlast) state_nxt = smks_pkg::ST_SORT_RD;
			end
			smks_pkg::ST_SORT_RD: begin
				state_nxt = ins_more ? smks_pkg::ST_SORT_KEY : smks_pkg::ST_OUT_RD;
			end
			smks_pkg::ST_SORT_KEY: state_nxt = smks_pkg::ST_SORT_CMP;
			smks_pkg::ST_SORT_CMP: begin
				if (!move_up) state_nxt = smks_pkg::ST_SORT_RD;
				else if (pos_q == AW'(1)) state_nxt = smks_pkg::ST_SORT_PUT;
			end
			smks_pkg::ST_SORT_PUT: state_nxt = smks_pkg::ST_SORT_RD;
			smks_pkg::ST_OUT_RD: begin
				if (out_free) state_nxt = smks_pkg::ST_OUT_LD;
			end
			smks_pkg::ST_OUT_LD: begin
				state_nxt = last_entry ? smks_pkg::ST_LOAD : smks_pkg::ST_OUT_RD;
			end
			default: state_nxt = smks_pkg::ST_LOAD;
		endcase
	end

	// RAM port control and input ready
	always_comb begin
		s_tready  = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = pos_q;
		ram_wdata = cur_q;
		ram_re    = 1'b0;
		ram_raddr = rd_idx_q;
		unique case (state_q)
			smks_pkg::ST_LOAD: begin
				s_tready  = 1'b1;
				ram_we    = in_acc && has_room;
				ram_waddr = count_q[AW-1:0];
				ram_wdata = s_tdata;
			end
			smks_pkg::ST_SORT_RD: begin
				ram_re    = ins_more;
				ram_raddr = ins_q[AW-1:0];
			end
			smks_pkg::ST_SORT_KEY: begin
				ram_re    = 1'b1;
				ram_raddr = ins_q[AW-1:0] - AW'(1);
			end
			smks_pkg::ST_SORT_CMP: begin
				// shift neighbor right into the hole, or drop the element in
				ram_we = 1'b1;
				if (move_up) begin
					ram_wdata = ram_rdata;
					ram_re    = pos_q > AW'(1);
					ram_raddr = pos_q - AW'(2);
				end
			end
			smks_pkg::ST_SORT_PUT: ram_we = 1'b1;
			smks_pkg::ST_OUT_RD: ram_re = out_free;
			smks_pkg::ST_OUT_LD: ram_re = 1'b0;
			default: ram_re = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= smks_pkg::ST_LOAD;
			mask_q   <= '1;
			count_q  <= '0;
			ovf_q    <= 1'b0;
			ins_q    <= '0;
			pos_q    <= '0;
			rd_idx_q <= '0;
		end else begin
			state_q <= state_nxt;
			if (cfg_wen) mask_q <= cfg_wdata;
			unique case (state_q)
				smks_pkg::ST_LOAD: begin
					if (in_acc) begin
						if (has_room) count_q <= count_q + CW'(1);
						else ovf_q <= 1'b1;
						if (s_tlast) ins_q <= CW'(1);
					end
				end
				smks_pkg::ST_SORT_RD: rd_idx_q <= '0;
				smks_pkg::ST_SORT_KEY: pos_q <= ins_q[AW-1:0];
				smks_pkg::ST_SORT_CMP: begin
					if (move_up) pos_q <= pos_q - AW'(1);
					else ins_q <= ins_q + CW'(1);
				end
				smks_pkg::ST_SORT_PUT: ins_q <= ins_q + CW'(1);
				smks_pkg::ST_OUT_RD: rd_idx_q <= rd_idx_q;
				smks_pkg::ST_OUT_LD: begin
					if (last_entry) begin
						count_q <= '0;
						ovf_q   <= 1'b0;
					end else begin
						rd_idx_q <= rd_idx_q + AW'(1);
					end
				end
				default: ovf_q <= ovf_q;
			endcase
		end
	end

	// element held aside during insertion
	always_ff @(posedge clk) begin
		if (state_q == smks_pkg::ST_SORT_KEY) cur_q <= ram_rdata;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == smks_pkg::ST_OUT_LD) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == smks_pkg::ST_OUT_LD) begin
			out_data_q <= ram_rdata;
			out_last_q <= last_entry;
			out_drop_q <= ovf_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_drop_q;

endmodule

// ===== src/smks_ram.sv =====
// Simple dual-port RAM: one write port, one read port, registered read data.
// Generic; no package dependencies.
module smks_ram #(
	parameter int DEPTH = 32,
	parameter int WIDTH = 64,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== test/smks_sort_checker.sv =====
`timescale 1ns / 100ps
// Checker for the stable masked key sorter: watches the request, result and
// config channels, predicts each sorted run and compares it. Uses smks_pkg.
module smks_sort_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	input  logic                         s_tready,
	input  logic [smks_pkg::ENTRY_W-1:0] s_tdata,
	input  logic                         s_tlast,
	input  logic                         m_tvalid,
	input  logic                         m_tready,
	input  logic [smks_pkg::ENTRY_W-1:0] m_tdata,
	input  logic                         m_tlast,
	input  logic                         m_tuser,
	input  logic                         cfg_wen,
	input  logic [smks_pkg::WORD_W-1:0]  cfg_wdata,
	output int                           mismatches,
	output int                           results_owed
);

	localparam int PRINT_CAP = 60;
	localparam int WW        = smks_pkg::WORD_W;
	localparam int EW        = smks_pkg::ENTRY_W;

	typedef logic [WW-1:0] word_t;

	typedef struct packed {
		word_t action;
		word_t extra;
		logic  eol;
		logic  dropped;
	} sorted_pair_t;

	sorted_pair_t sorted_owed[$];   // results still to come, oldest first
	word_t        list_action[$];   // pairs of the list being loaded
	word_t        list_extra[$];
	logic         list_overflow;
	word_t        key_mask;
	int           printed;

	initial begin
		mismatches   = 0;
		results_owed = 0;
		printed      = 0;
	end

	task automatic report_mismatch(input string what, input word_t got, input word_t want);
		mismatches++;
		if (printed < PRINT_CAP)
			$display("%0t mismatch: %s got %08h want %08h", $realtime, what, got, want);
		printed++;
	endtask

	function automatic logic signed [WW-1:0] masked_key(input word_t word, input word_t mask);
		return $signed(word & mask);
	endfunction

	// stable insertion sort of the loaded list, queued as the expected run
	task automatic predict_sorted_run();
		word_t act [smks_pkg::MAX_ACTIONS];
		word_t ext [smks_pkg::MAX_ACTIONS];
		word_t a_hold;
		word_t e_hold;
		int    n;
		int    pos;
		n = list_action.size();
		for (int i = 0; i < n; i++) begin
			act[i] = list_action[i];
			ext[i] = list_extra[i];
		end
		for (int i = 1; i < n; i++) begin
			a_hold = act[i];
			e_hold = ext[i];
			pos    = i;
			while (pos > 0 && masked_key(act[pos-1], key_mask) > masked_key(a_hold, key_mask)) begin
				act[pos] = act[pos-1];
				ext[pos] = ext[pos-1];
				pos--;
			end
			act[pos] = a_hold;
			ext[pos] = e_hold;
		end
		for (int k = 0; k < n; k++)
			sorted_owed.push_back('{act[k], ext[k], (k == n - 1), list_overflow});
		list_action.delete();
		list_extra.delete();
		list_overflow = 1'b0;
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		sorted_pair_t want;
		if (!arst_n) begin
			key_mask      = '1;
			list_overflow = 1'b0;
			list_action.delete();
			list_extra.delete();
			sorted_owed.delete();
		end else begin
			// results first: they always belong to runs queued earlier
			if (m_tvalid && m_tready) begin
				if (sorted_owed.size() == 0) begin
					report_mismatch("result with none owed", m_tdata[WW-1:0], '0);
				end else begin
					want = sorted_owed.pop_front();
					if (m_tdata[WW-1:0] !== want.action)
						report_mismatch("sorted_action", m_tdata[WW-1:0], want.action);
					if (m_tdata[EW-1:WW] !== want.extra)
						report_mismatch("sorted_extra", m_tdata[EW-1:WW], want.extra);
					if (m_tlast !== want.eol)
						report_mismatch("end_of_list", word_t'(m_tlast), word_t'(want.eol));
					if (m_tuser !== want.dropped)
						report_mismatch("items_dropped", word_t'(m_tuser),
							word_t'(want.dropped));
				end
			end
			if (s_tvalid && s_tready) begin
				if (list_action.size() < smks_pkg::MAX_ACTIONS) begin
					list_action.push_back(s_tdata[WW-1:0]);
					list_extra.push_back(s_tdata[EW-1:WW]);
				end else begin
					list_overflow = 1'b1;
				end
				if (s_tlast)
					predict_sorted_run();
			end
			if (cfg_wen)
				key_mask = cfg_wdata;
		end
		results_owed = sorted_owed.size();
	end

endmodule

// ===== test/tb_stable_masked_key_sorter.sv =====
`timescale 1ns / 100ps
// Testbench top for the stable masked key sorter: clock, reset, request and
// config stimulus, result back-pressure and verdict. Uses smks_pkg, smks_sort_checker.
module tb_stable_masked_key_sorter;

	localparam int HALF_PERIOD   = 6;
	localparam int RESET_CYCLES  = 11;
	localparam int SETTLE_CYCLES = 40;       // idle margin before a mask write
	localparam int TAIL_CYCLES   = 150;      // quiet time after the last result
	localparam int HOLD_CYCLES   = 700;      // long back-pressure stretch
	localparam int PHASE_COUNT   = 8;
	localparam int PHASE_ITEMS   = 32;       // minimum requests per random phase
	localparam int TIMEOUT_NS    = 12 * 600_000;

	logic                         clk;
	logic                         arst_n;
	logic                         s_tvalid;
	logic                         s_tready;
	logic [smks_pkg::ENTRY_W-1:0] s_tdata;     // [31:0] action_word, [63:32] extra_word
	logic                         s_tlast;     // last_item
	logic                         m_tvalid;
	logic                         m_tready;
	logic [smks_pkg::ENTRY_W-1:0] m_tdata;     // [31:0] sorted_action, [63:32] sorted_extra
	logic                         m_tlast;     // end_of_list
	logic                         m_tuser;     // items_dropped
	logic                         cfg_wen;
	logic [smks_pkg::WORD_W-1:0]  cfg_wdata;   // time_key_mask

	int mismatches;
	int results_owed;
	int src_idle_pct;    // chance per cycle that the sender holds back
	int rcv_stall_pct;   // chance per cycle that the receiver stalls
	int holds_asked;     // long receiver hold-offs requested by the stimulus
	int holds_served;    // ... and started by the receiver process

	stable_masked_key_sorter uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata)
	);

	smks_sort_checker chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.s_tlast      (s_tlast),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.m_tlast      (m_tlast),
		.m_tuser      (m_tuser),
		.cfg_wen      (cfg_wen),
		.cfg_wdata    (cfg_wdata),
		.mismatches   (mismatches),
		.results_owed (results_owed)
	);

	always begin
		clk = 1'b0;
		#HALF_PERIOD;
		clk = 1'b1;
		#HALF_PERIOD;
	end

	// Hard stop in case a handshake never completes.
	initial begin
		#TIMEOUT_NS;
		$display("[stable_masked_key_sorter] ERROR");
		$finish;
	end

	// Result receiver. Stalls at random at the current rate; when a long
	// hold-off is asked for it keeps tready low for HOLD_CYCLES, counted here,
	// so the block fills up and the sender sees s_tready drop.
	initial begin
		m_tready     = 1'b0;
		holds_served = 0;
		forever begin
			@(posedge clk);
			if (holds_served != holds_asked) begin
				holds_served++;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(posedge clk);
			end else begin
				m_tready <= ($urandom_range(99) >= rcv_stall_pct);
			end
		end
	end

	// One request; returns at the edge where it was taken. Valid stays high
	// across back-to-back requests, so it is only lowered for a real gap.
	task automatic send_request(input logic [smks_pkg::WORD_W-1:0] action,
			input logic [smks_pkg::WORD_W-1:0] extra, input logic last);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {extra, action};
		s_tlast  <= last;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	// Sender pause: nothing offered until every owed result is in, then a
	// margin so the block is surely idle before any mask write.
	task automatic await_sorted_runs();
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (results_owed != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_key_mask(input logic [smks_pkg::WORD_W-1:0] mask);
		cfg_wen   <= 1'b1;
		cfg_wdata <= mask;
		@(posedge clk);
		cfg_wen   <= 1'b0;
	endtask

	// Mostly random words; some corner words so equal keys and sign
	// boundaries show up often even under a full mask.
	function automatic logic [smks_pkg::WORD_W-1:0] pick_action();
		int sel;
		sel = $urandom_range(11);
		case (sel)
			0:       return 32'h0000_0000;
			1:       return 32'h8000_0000;
			2:       return 32'hFFFF_FFFF;
			3:       return 32'h7FFF_FFFF;
			4:       return 32'h0000_0001;
			default: return $urandom();
		endcase
	endfunction

	// Key masks per phase: both extremes, the sign bit alone, narrow fields.
	function automatic logic [smks_pkg::WORD_W-1:0] phase_mask(input int ph);
		case (ph)
			0:       return 32'hFFFF_FFFF;
			1:       return 32'h8000_0000;
			2:       return 32'h0000_000F;
			3:       return 32'hFFFF_0000;
			4:       return 32'h7FFF_FFFF;
			5:       return $urandom();
			6:       return 32'h0000_0000;
			default: return 32'h8000_00FF;
		endcase
	endfunction

	// Mostly short lists, some up to capacity, some overflowing it.
	function automatic int pick_list_len();
		int r;
		r = $urandom_range(99);
		if (r < 65)
			return $urandom_range(8, 1);
		else if (r < 85)
			return $urandom_range(smks_pkg::MAX_ACTIONS, 9);
		else
			return $urandom_range(smks_pkg::MAX_ACTIONS + 8, smks_pkg::MAX_ACTIONS + 1);
	endfunction

	task automatic send_list(input int len);
		for (int k = 0; k < len; k++)
			send_request(pick_action(), $urandom(), (k == len - 1));
	endtask

	initial begin
		int sent;
		int len;
		int lists;
		arst_n        = 1'b0;
		s_tvalid      = 1'b0;
		s_tdata       = '0;
		s_tlast       = 1'b0;
		cfg_wen       = 1'b0;
		cfg_wdata     = '0;
		src_idle_pct  = 0;
		rcv_stall_pct = 0;
		holds_asked   = 0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed part, mask still at its reset value (all ones) ---
		// single-entry list
		send_request(32'hFFFF_FFFF, 32'h0000_0000, 1'b1);
		// signed extremes, duplicate keys must keep arrival order
		send_request(32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0);
		send_request(32'h8000_0000, 32'h0000_0000, 1'b0);
		send_request(32'h0000_0000, 32'h1111_1111, 1'b0);
		send_request(32'hFFFF_FFFF, 32'h2222_2222, 1'b0);
		send_request(32'h8000_0000, 32'h3333_3333, 1'b0);
		send_request(32'h0000_0001, 32'h4444_4444, 1'b1);
		await_sorted_runs();

		// narrow field: different action words collapse onto equal keys
		write_key_mask(32'h0000_FF00);
		send_request(32'hABCD_1200, 32'h0000_0001, 1'b0);
		send_request(32'h0000_0300, 32'h0000_0002, 1'b0);
		send_request(32'h1234_12FF, 32'h0000_0003, 1'b0);
		send_request(32'hFFFF_00FF, 32'h0000_0004, 1'b0);
		send_request(32'h0000_1200, 32'h0000_0005, 1'b1);
		await_sorted_runs();

		// empty mask: every key is zero, output order is arrival order
		write_key_mask(32'h0000_0000);
		send_request(32'hFFFF_FFFF, 32'hAAAA_AAAA, 1'b0);
		send_request(32'h8000_0000, 32'h5555_5555, 1'b0);
		send_request(32'h0000_0000, 32'hFFFF_FFFF, 1'b1);
		await_sorted_runs();

		// --- random phases, each with its own mask and flow pattern ---
		for (int ph = 0; ph < PHASE_COUNT; ph++) begin
			write_key_mask(phase_mask(ph));
			case (ph % 4)
				0: begin src_idle_pct = 0;  rcv_stall_pct = 0;  end
				1: begin src_idle_pct = 84; rcv_stall_pct = 0;  end
				2: begin src_idle_pct = 0;  rcv_stall_pct = 84; end
				default: begin src_idle_pct = 30; rcv_stall_pct = 30; end
			endcase
			// receiver goes quiet for a long stretch while requests keep coming
			if (ph == 4)
				holds_asked++;
			sent  = 0;
			lists = 0;
			while (sent < PHASE_ITEMS) begin
				// first phase starts with one overflowing list (final request
				// dropped too) and one that exactly fills the store
				if (ph == 0 && lists == 0)
					len = smks_pkg::MAX_ACTIONS + 1;
				else if (ph == 0 && lists == 1)
					len = smks_pkg::MAX_ACTIONS;
				else
					len = pick_list_len();
				send_list(len);
				sent += len;
				lists++;
			end
			await_sorted_runs();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("[stable_masked_key_sorter] OK");
		else
			$display("[stable_masked_key_sorter] ERROR");
		$finish;
	end

endmodule
